FILE: design/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg
// Shared types, codes and the step microprogram of the Lorenz RK4 integrator.
// ----------------------------------------------------------------------------
package lrk_pkg;

    typedef enum logic {
        OPER_STEP    = 1'b0,
        OPER_RESTART = 1'b1
    } oper_t;

    typedef enum logic [2:0] {
        CFG_SIGMA     = 3'd0,
        CFG_RHO       = 3'd1,
        CFG_BETA      = 3'd2,
        CFG_TIME_STEP = 3'd3,
        CFG_BURN_IN   = 3'd4,
        CFG_STOP      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV6
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_SIGMA,
        SRC_RHO,
        SRC_BETA,
        SRC_HALF,
        SRC_TS,
        SRC_PX,
        SRC_PY,
        SRC_PZ,
        SRC_QX,
        SRC_QY,
        SRC_QZ,
        SRC_KX,
        SRC_KY,
        SRC_KZ,
        SRC_SX,
        SRC_SY,
        SRC_SZ,
        SRC_T,
        SRC_U
    } src_t;

    typedef enum logic [3:0] {
        DST_PX,
        DST_PY,
        DST_PZ,
        DST_QX,
        DST_QY,
        DST_QZ,
        DST_KX,
        DST_KY,
        DST_KZ,
        DST_SX,
        DST_SY,
        DST_SZ,
        DST_T,
        DST_U
    } dst_t;

    localparam int DST_COUNT = 14;

    typedef enum logic [1:0] {
        SEG_DERIV,
        SEG_ACC,
        SEG_QUP,
        SEG_FINAL
    } seg_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ISSUE,
        CS_WAIT
    } core_state_t;

    typedef struct packed {
        logic start;
        logic load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t d;
    } uop_t;

    localparam logic [3:0] DIVISOR = 4'd6;

    function automatic src_t k_src(logic [1:0] c);
        src_t r;
        case (c)
            2'd0:    r = SRC_KX;
            2'd1:    r = SRC_KY;
            default: r = SRC_KZ;
        endcase
        return r;
    endfunction

    function automatic src_t s_src(logic [1:0] c);
        src_t r;
        case (c)
            2'd0:    r = SRC_SX;
            2'd1:    r = SRC_SY;
            default: r = SRC_SZ;
        endcase
        return r;
    endfunction

    function automatic src_t p_src(logic [1:0] c);
        src_t r;
        case (c)
            2'd0:    r = SRC_PX;
            2'd1:    r = SRC_PY;
            default: r = SRC_PZ;
        endcase
        return r;
    endfunction

    function automatic dst_t s_dst(logic [1:0] c);
        dst_t r;
        case (c)
            2'd0:    r = DST_SX;
            2'd1:    r = DST_SY;
            default: r = DST_SZ;
        endcase
        return r;
    endfunction

    function automatic dst_t q_dst(logic [1:0] c);
        dst_t r;
        case (c)
            2'd0:    r = DST_QX;
            2'd1:    r = DST_QY;
            default: r = DST_QZ;
        endcase
        return r;
    endfunction

    function automatic dst_t p_dst(logic [1:0] c);
        dst_t r;
        case (c)
            2'd0:    r = DST_PX;
            2'd1:    r = DST_PY;
            default: r = DST_PZ;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] seg_last(logic [1:0] stage, seg_t seg);
        logic [3:0] r;
        unique case (seg)
            SEG_DERIV: r = 4'd7;
            SEG_ACC:   r = (stage == 2'd0 || stage == 2'd3) ? 4'd2 : 4'd5;
            SEG_QUP:   r = 4'd5;
            SEG_FINAL: r = 4'd8;
            default:   r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic uop_t uop(logic [1:0] stage, seg_t seg, logic [3:0] idx);
        uop_t       u;
        src_t       h;
        logic [1:0] c;
        u = '{op: OP_ADD, a: SRC_ZERO, b: SRC_ZERO, d: DST_T};
        h = (stage == 2'd2) ? SRC_TS : SRC_HALF;
        c = idx[2:1];
        unique case (seg)
            SEG_DERIV:
            begin
                unique case (idx[2:0])
                    3'd0:    u = '{op: OP_SUB, a: SRC_QY,    b: SRC_QX, d: DST_T};
                    3'd1:    u = '{op: OP_MUL, a: SRC_SIGMA, b: SRC_T,  d: DST_KX};
                    3'd2:    u = '{op: OP_SUB, a: SRC_RHO,   b: SRC_QZ, d: DST_T};
                    3'd3:    u = '{op: OP_MUL, a: SRC_QX,    b: SRC_T,  d: DST_T};
                    3'd4:    u = '{op: OP_SUB, a: SRC_T,     b: SRC_QY, d: DST_KY};
                    3'd5:    u = '{op: OP_MUL, a: SRC_QX,    b: SRC_QY, d: DST_T};
                    3'd6:    u = '{op: OP_MUL, a: SRC_BETA,  b: SRC_QZ, d: DST_U};
                    default: u = '{op: OP_SUB, a: SRC_T,     b: SRC_U,  d: DST_KZ};
                endcase
            end
            SEG_ACC:
            begin
                if (stage == 2'd0)
                begin
                    u = '{op: OP_ADD, a: k_src(idx[1:0]), b: SRC_ZERO, d: s_dst(idx[1:0])};
                end
                else if (stage == 2'd3)
                begin
                    u = '{op: OP_ADD, a: s_src(idx[1:0]), b: k_src(idx[1:0]),
                          d: s_dst(idx[1:0])};
                end
                else if (!idx[0])
                begin
                    u = '{op: OP_ADD, a: k_src(c), b: k_src(c), d: DST_T};
                end
                else
                begin
                    u = '{op: OP_ADD, a: s_src(c), b: SRC_T, d: s_dst(c)};
                end
            end
            SEG_QUP:
            begin
                if (!idx[0])
                begin
                    u = '{op: OP_MUL, a: k_src(c), b: h, d: DST_T};
                end
                else
                begin
                    u = '{op: OP_ADD, a: p_src(c), b: SRC_T, d: q_dst(c)};
                end
            end
            SEG_FINAL:
            begin
                if (idx < 4'd3)
                begin
                    c = 2'd0;
                end
                else if (idx < 4'd6)
                begin
                    c = 2'd1;
                end
                else
                begin
                    c = 2'd2;
                end
                unique case (idx) inside
                    4'd0, 4'd3, 4'd6: u = '{op: OP_MUL, a: s_src(c), b: SRC_TS, d: DST_T};
                    4'd1, 4'd4, 4'd7: u = '{op: OP_DIV6, a: SRC_T, b: SRC_ZERO, d: DST_T};
                    default:          u = '{op: OP_ADD, a: p_src(c), b: SRC_T, d: p_dst(c)};
                endcase
            end
            default: u = '{op: OP_ADD, a: SRC_ZERO, b: SRC_ZERO, d: DST_T};
        endcase
        return u;
    endfunction

endpackage

FILE: design/lrk_if.sv
// ----------------------------------------------------------------------------
// lrk_if
// Valid/ready channels of the Lorenz RK4 integrator: command words in,
// trajectory point words out.
// ----------------------------------------------------------------------------
interface lrk_cmd_if #(
    parameter int VALUE_WIDTH = 48
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [VALUE_WIDTH-1:0] start_x;
    logic signed [VALUE_WIDTH-1:0] start_y;
    logic signed [VALUE_WIDTH-1:0] start_z;

    modport source (output valid, operation, start_x, start_y, start_z, input ready);
    modport sink (input valid, operation, start_x, start_y, start_z, output ready);
endinterface

interface lrk_point_if #(
    parameter int VALUE_WIDTH = 48,
    parameter int COUNT_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic        [COUNT_WIDTH-1:0] step_index;
    logic signed [VALUE_WIDTH-1:0] point_x;
    logic signed [VALUE_WIDTH-1:0] point_y;
    logic signed [VALUE_WIDTH-1:0] point_z;

    modport source (output valid, step_index, point_x, point_y, point_z, input ready);
    modport sink (input valid, step_index, point_x, point_y, point_z, output ready);
endinterface

FILE: design/lrk_mul.sv
// ----------------------------------------------------------------------------
// lrk_mul
// Bit-serial signed fixed-point multiplier: one multiplier bit per cycle,
// then floor shift by the fraction width and saturation.
// ----------------------------------------------------------------------------
module lrk_mul #(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 36
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] a,
    input  logic signed [VALUE_WIDTH-1:0] b,
    output logic signed [VALUE_WIDTH-1:0] result,
    output logic                          done
);
    localparam int W     = VALUE_WIDTH;
    localparam int P     = 2 * W + 1;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     ma_reg;
    logic [W-1:0]     mb_reg;
    logic [W-1:0]     hi_reg;
    logic [W-1:0]     lo_reg;
    logic             neg_reg;
    logic [W-1:0]     result_reg;

    logic             last;
    logic [W:0]       sum;
    logic [P-1:0]     mag;
    logic [P-1:0]     sp;
    logic [P-1:0]     sh;
    logic             fits;
    logic [W-1:0]     sat_next;

    assign last = (cnt_reg == CNT_W'(W - 1));
    assign sum  = {1'b0, hi_reg} + (mb_reg[0] ? {1'b0, ma_reg} : '0);

    always_comb
    begin
        mag  = {1'b0, hi_reg, lo_reg};
        sp   = neg_reg ? (~mag + P'(1)) : mag;
        sh   = P'($signed(sp) >>> FRACTION_BITS);
        fits = (&sh[P-1:W-1]) || !(|sh[P-1:W-1]);
        if (fits)
        begin
            sat_next = sh[W-1:0];
        end
        else
        begin
            sat_next = sp[P-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[W-1] ? (~a + W'(1)) : a;
            mb_reg  <= b[W-1] ? (~b + W'(1)) : b;
            hi_reg  <= '0;
            lo_reg  <= '0;
            neg_reg <= a[W-1] ^ b[W-1];
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[W:1];
            lo_reg <= {sum[0], lo_reg[W-1:1]};
            mb_reg <= {1'b0, mb_reg[W-1:1]};
        end
        if (fin_reg)
        begin
            result_reg <= sat_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

FILE: design/lrk_div6.sv
// ----------------------------------------------------------------------------
// lrk_div6
// Bit-serial divide by six, truncating toward zero: one dividend bit per
// cycle through a three-bit remainder.
// ----------------------------------------------------------------------------
module lrk_div6 #(
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] a,
    output logic signed [VALUE_WIDTH-1:0] result,
    output logic                          done
);
    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     mag_reg;
    logic [W-1:0]     quo_reg;
    logic [2:0]       rem_reg;
    logic             neg_reg;
    logic [W-1:0]     result_reg;

    logic             last;
    logic [3:0]       r;
    logic [3:0]       r_sub;
    logic             ge;

    assign last  = (cnt_reg == CNT_W'(W - 1));
    assign r     = {rem_reg, mag_reg[W-1]};
    assign r_sub = r - lrk_pkg::DIVISOR;
    assign ge    = (r >= lrk_pkg::DIVISOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= a[W-1] ? (~a + W'(1)) : a;
            neg_reg <= a[W-1];
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], ge};
            rem_reg <= ge ? r_sub[2:0] : r[2:0];
        end
        if (fin_reg)
        begin
            result_reg <= neg_reg ? (~quo_reg + W'(1)) : quo_reg;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

FILE: design/lrk_core.sv
// ----------------------------------------------------------------------------
// lrk_core
// Microprogrammed RK4 step sequencer: register file, saturating adder and
// the serial multiply and divide units.
// ----------------------------------------------------------------------------
module lrk_core #(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 36
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrk_pkg::cmd_t                 cmd,
    input  logic signed [VALUE_WIDTH-1:0] load_x,
    input  logic signed [VALUE_WIDTH-1:0] load_y,
    input  logic signed [VALUE_WIDTH-1:0] load_z,
    input  logic signed [VALUE_WIDTH-1:0] sigma,
    input  logic signed [VALUE_WIDTH-1:0] rho,
    input  logic signed [VALUE_WIDTH-1:0] beta,
    input  logic        [VALUE_WIDTH-2:0] time_step,
    output logic                          busy,
    output logic signed [VALUE_WIDTH-1:0] pos_x,
    output logic signed [VALUE_WIDTH-1:0] pos_y,
    output logic signed [VALUE_WIDTH-1:0] pos_z
);
    localparam int W = VALUE_WIDTH;
    localparam logic [127:0] ONE_Q  = 128'd1 << FRACTION_BITS;
    localparam logic [127:0] VMAX_Q = (128'd1 << (W - 1)) - 128'd1;
    localparam logic [127:0] ONE_R  = (ONE_Q > VMAX_Q) ? VMAX_Q : ONE_Q;
    localparam logic [W-1:0] VMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN   = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] rf_reg [lrk_pkg::DST_COUNT];

    lrk_pkg::core_state_t state_reg, state_next;
    logic [1:0]           stage_reg, stage_next;
    lrk_pkg::seg_t        seg_reg, seg_next;
    logic [3:0]           idx_reg, idx_next;

    lrk_pkg::uop_t       u;
    logic signed [W-1:0] a_val;
    logic signed [W-1:0] b_val;
    logic [W:0]          sum;
    logic [W-1:0]        alu;
    logic                wr_en;
    logic [W-1:0]        wr_data;
    logic                adv;
    logic                mul_start;
    logic                div_start;
    logic signed [W-1:0] mul_res;
    logic signed [W-1:0] div_res;
    logic                mul_done;
    logic                div_done;

    function automatic logic signed [W-1:0] operand(lrk_pkg::src_t s);
        logic signed [W-1:0] v;
        unique case (s)
            lrk_pkg::SRC_ZERO:  v = '0;
            lrk_pkg::SRC_SIGMA: v = sigma;
            lrk_pkg::SRC_RHO:   v = rho;
            lrk_pkg::SRC_BETA:  v = beta;
            lrk_pkg::SRC_HALF:  v = {2'b00, time_step[W-2:1]};
            lrk_pkg::SRC_TS:    v = {1'b0, time_step};
            lrk_pkg::SRC_PX:    v = rf_reg[lrk_pkg::DST_PX];
            lrk_pkg::SRC_PY:    v = rf_reg[lrk_pkg::DST_PY];
            lrk_pkg::SRC_PZ:    v = rf_reg[lrk_pkg::DST_PZ];
            lrk_pkg::SRC_QX:    v = rf_reg[lrk_pkg::DST_QX];
            lrk_pkg::SRC_QY:    v = rf_reg[lrk_pkg::DST_QY];
            lrk_pkg::SRC_QZ:    v = rf_reg[lrk_pkg::DST_QZ];
            lrk_pkg::SRC_KX:    v = rf_reg[lrk_pkg::DST_KX];
            lrk_pkg::SRC_KY:    v = rf_reg[lrk_pkg::DST_KY];
            lrk_pkg::SRC_KZ:    v = rf_reg[lrk_pkg::DST_KZ];
            lrk_pkg::SRC_SX:    v = rf_reg[lrk_pkg::DST_SX];
            lrk_pkg::SRC_SY:    v = rf_reg[lrk_pkg::DST_SY];
            lrk_pkg::SRC_SZ:    v = rf_reg[lrk_pkg::DST_SZ];
            lrk_pkg::SRC_T:     v = rf_reg[lrk_pkg::DST_T];
            lrk_pkg::SRC_U:     v = rf_reg[lrk_pkg::DST_U];
            default:            v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        u     = lrk_pkg::uop(stage_reg, seg_reg, idx_reg);
        a_val = operand(u.a);
        b_val = operand(u.b);
        if (u.op == lrk_pkg::OP_SUB)
        begin
            sum = {a_val[W-1], a_val} - {b_val[W-1], b_val};
        end
        else
        begin
            sum = {a_val[W-1], a_val} + {b_val[W-1], b_val};
        end
        if (sum[W] != sum[W-1])
        begin
            alu = sum[W] ? VMIN : VMAX;
        end
        else
        begin
            alu = sum[W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_data    = alu;
        adv        = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            lrk_pkg::CS_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = lrk_pkg::CS_ISSUE;
                    stage_next = 2'd0;
                    seg_next   = lrk_pkg::SEG_DERIV;
                    idx_next   = 4'd0;
                end
            end
            lrk_pkg::CS_ISSUE:
            begin
                if (u.op == lrk_pkg::OP_ADD || u.op == lrk_pkg::OP_SUB)
                begin
                    wr_en = 1'b1;
                    adv   = 1'b1;
                end
                else
                begin
                    mul_start  = (u.op == lrk_pkg::OP_MUL);
                    div_start  = (u.op == lrk_pkg::OP_DIV6);
                    state_next = lrk_pkg::CS_WAIT;
                end
            end
            lrk_pkg::CS_WAIT:
            begin
                if (mul_done || div_done)
                begin
                    wr_en   = 1'b1;
                    wr_data = (u.op == lrk_pkg::OP_MUL) ? mul_res : div_res;
                    adv     = 1'b1;
                end
            end
            default: state_next = lrk_pkg::CS_IDLE;
        endcase
        if (adv)
        begin
            state_next = lrk_pkg::CS_ISSUE;
            if (idx_reg == lrk_pkg::seg_last(stage_reg, seg_reg))
            begin
                idx_next = 4'd0;
                unique case (seg_reg)
                    lrk_pkg::SEG_DERIV: seg_next = lrk_pkg::SEG_ACC;
                    lrk_pkg::SEG_ACC:
                    begin
                        seg_next = (stage_reg == 2'd3) ? lrk_pkg::SEG_FINAL
                                                       : lrk_pkg::SEG_QUP;
                    end
                    lrk_pkg::SEG_QUP:
                    begin
                        seg_next   = lrk_pkg::SEG_DERIV;
                        stage_next = stage_reg + 2'd1;
                    end
                    default: state_next = lrk_pkg::CS_IDLE;
                endcase
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrk_pkg::CS_IDLE;
            stage_reg <= 2'd0;
            seg_reg   <= lrk_pkg::SEG_DERIV;
            idx_reg   <= 4'd0;
            for (int i = 0; i < lrk_pkg::DST_COUNT; i++)
            begin
                rf_reg[i] <= ONE_R[W-1:0];
            end
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
            if (cmd.load)
            begin
                rf_reg[lrk_pkg::DST_PX] <= load_x;
                rf_reg[lrk_pkg::DST_PY] <= load_y;
                rf_reg[lrk_pkg::DST_PZ] <= load_z;
            end
            else if (state_reg == lrk_pkg::CS_IDLE && cmd.start)
            begin
                rf_reg[lrk_pkg::DST_QX] <= rf_reg[lrk_pkg::DST_PX];
                rf_reg[lrk_pkg::DST_QY] <= rf_reg[lrk_pkg::DST_PY];
                rf_reg[lrk_pkg::DST_QZ] <= rf_reg[lrk_pkg::DST_PZ];
            end
            else if (wr_en)
            begin
                rf_reg[u.d] <= wr_data;
            end
        end
    end

    lrk_mul #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (a_val),
        .b      (b_val),
        .result (mul_res),
        .done   (mul_done)
    );

    lrk_div6 #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div6 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (a_val),
        .result (div_res),
        .done   (div_done)
    );

    assign busy  = (state_reg != lrk_pkg::CS_IDLE);
    assign pos_x = rf_reg[lrk_pkg::DST_PX];
    assign pos_y = rf_reg[lrk_pkg::DST_PY];
    assign pos_z = rf_reg[lrk_pkg::DST_PZ];

    a_wait_has_unit_op: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrk_pkg::CS_WAIT |-> (u.op == lrk_pkg::OP_MUL || u.op == lrk_pkg::OP_DIV6))
        else $error("waiting on a unit for an adder op");

    a_one_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("both serial units finished together");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || div_done) |-> state_reg == lrk_pkg::CS_WAIT)
        else $error("unit result arrived outside the wait state");

endmodule

FILE: design/lorenz_rk4_integrator_top.sv
// ----------------------------------------------------------------------------
// lorenz_rk4_integrator_top
// Lorenz system integrator, classic RK4 in saturating signed fixed point.
//
// Channels: cmd takes command words (operation, start point); point returns
// the trajectory word (step index and the point before the step). Registers
// are written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A restart word loads the start point and clears the step count and returns
// nothing. A step word returns its point through the output register when
// burn-in is reached and stop is not, and nothing otherwise; a step at or
// past stop is dropped. Each step word runs 28 serial multiplies and 3 serial
// divides by six, one bit per cycle, through the shared units; cmd.ready
// stays low until the step is done.
// Reset loads sigma 10, rho 28, beta 8/3, dt 1e-4, point (1,1,1), count 0.
// A stalled receiver holds the output word; one further word parks in a
// skid register, and cmd.ready also drops while that register is full.
// ----------------------------------------------------------------------------
module lorenz_rk4_integrator_top #(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 36,
    parameter int COUNT_WIDTH   = 32,
    localparam int CFG_WIDTH    = (VALUE_WIDTH > COUNT_WIDTH) ? VALUE_WIDTH : COUNT_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lrk_cmd_if.sink              cmd,
    lrk_point_if.source          point,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);
    localparam int W  = VALUE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int OW = CW + 3 * W;

    localparam logic [127:0] ONE_Q    = 128'd1 << FRACTION_BITS;
    localparam logic [127:0] VMAX_Q   = (128'd1 << (W - 1)) - 128'd1;
    localparam logic [127:0] SIGMA_Q  = ONE_Q * 128'd10;
    localparam logic [127:0] RHO_Q    = ONE_Q * 128'd28;
    localparam logic [127:0] BETA_Q   = (ONE_Q * 128'd8 + 128'd1) / 128'd3;
    localparam logic [127:0] TS_Q     = (ONE_Q + 128'd5000) / 128'd10000;
    localparam logic [127:0] SIGMA_R  = (SIGMA_Q > VMAX_Q) ? VMAX_Q : SIGMA_Q;
    localparam logic [127:0] RHO_R    = (RHO_Q > VMAX_Q) ? VMAX_Q : RHO_Q;
    localparam logic [127:0] BETA_R   = (BETA_Q > VMAX_Q) ? VMAX_Q : BETA_Q;
    localparam logic [127:0] TS_R     = (TS_Q > VMAX_Q) ? VMAX_Q : TS_Q;
    localparam logic [63:0]  BURN_R   = 64'd1000000;
    localparam logic [63:0]  STOP_R   = 64'd11000000;

    logic signed [W-1:0] sigma_reg;
    logic signed [W-1:0] rho_reg;
    logic signed [W-1:0] beta_reg;
    logic [W-2:0]        time_step_reg;
    logic [CW-1:0]       burn_in_reg;
    logic [CW-1:0]       stop_reg;
    logic [CW-1:0]       steps_reg, steps_next;

    logic                out_v_reg, out_v_next;
    logic [OW-1:0]       out_reg, out_next;
    logic                hold_v_reg, hold_v_next;
    logic [OW-1:0]       hold_reg, hold_next;

    lrk_pkg::cmd_t       core_cmd;
    logic                core_busy;
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic signed [W-1:0] pos_z;

    logic                cmd_fire;
    logic                out_fire;
    logic                is_restart;
    logic                step_go;
    logic                emit;

    assign cmd.ready  = !core_busy && !hold_v_reg;
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign out_fire   = out_v_reg && point.ready;
    assign is_restart = (lrk_pkg::oper_t'(cmd.operation) == lrk_pkg::OPER_RESTART);
    assign step_go    = !is_restart && (steps_reg < stop_reg);
    assign emit       = step_go && (steps_reg >= burn_in_reg);

    always_comb
    begin
        core_cmd       = '0;
        core_cmd.start = cmd_fire && step_go;
        core_cmd.load  = cmd_fire && is_restart;
    end

    always_comb
    begin
        steps_next = steps_reg;
        if (cmd_fire && is_restart)
        begin
            steps_next = '0;
        end
        else if (cmd_fire && step_go)
        begin
            steps_next = steps_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        if (out_fire)
        begin
            if (hold_v_reg)
            begin
                out_next    = hold_reg;
                hold_v_next = 1'b0;
            end
            else
            begin
                out_v_next = 1'b0;
            end
        end
        if (cmd_fire && emit)
        begin
            if (!out_v_next)
            begin
                out_next   = {steps_reg, pos_x, pos_y, pos_z};
                out_v_next = 1'b1;
            end
            else
            begin
                hold_next   = {steps_reg, pos_x, pos_y, pos_z};
                hold_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= SIGMA_R[W-1:0];
            rho_reg       <= RHO_R[W-1:0];
            beta_reg      <= BETA_R[W-1:0];
            time_step_reg <= TS_R[W-2:0];
            burn_in_reg   <= BURN_R[CW-1:0];
            stop_reg      <= STOP_R[CW-1:0];
            steps_reg     <= '0;
            out_v_reg     <= 1'b0;
            hold_v_reg    <= 1'b0;
        end
        else
        begin
            steps_reg  <= steps_next;
            out_v_reg  <= out_v_next;
            hold_v_reg <= hold_v_next;
            if (cfg_we)
            begin
                unique case (lrk_pkg::cfg_idx_t'(cfg_index))
                    lrk_pkg::CFG_SIGMA:     sigma_reg     <= cfg_data[W-1:0];
                    lrk_pkg::CFG_RHO:       rho_reg       <= cfg_data[W-1:0];
                    lrk_pkg::CFG_BETA:      beta_reg      <= cfg_data[W-1:0];
                    lrk_pkg::CFG_TIME_STEP: time_step_reg <= cfg_data[W-2:0];
                    lrk_pkg::CFG_BURN_IN:   burn_in_reg   <= cfg_data[CW-1:0];
                    lrk_pkg::CFG_STOP:      stop_reg      <= cfg_data[CW-1:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    lrk_core #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (core_cmd),
        .load_x    (cmd.start_x),
        .load_y    (cmd.start_y),
        .load_z    (cmd.start_z),
        .sigma     (sigma_reg),
        .rho       (rho_reg),
        .beta      (beta_reg),
        .time_step (time_step_reg),
        .busy      (core_busy),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z)
    );

    assign point.valid      = out_v_reg;
    assign point.step_index = out_reg[OW-1:3*W];
    assign point.point_x    = out_reg[3*W-1:2*W];
    assign point.point_y    = out_reg[2*W-1:W];
    assign point.point_z    = out_reg[W-1:0];

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg |-> out_v_reg)
        else $error("skid word held while output register empty");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && is_restart) |=> steps_reg == '0)
        else $error("restart did not clear the step count");

    a_stop_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && !is_restart && steps_reg >= stop_reg) |=> $stable(steps_reg))
        else $error("step count moved at or past stop");

    a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(core_busy) |-> $past(cmd_fire))
        else $error("core started without an accepted word");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Lorenz RK4 integrator: drives command words,
// predicts the trajectory words in fixed point (typed rows give their own) and compares field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VW = 48;
    localparam int FB = 36;
    localparam int CW = 32;
    localparam int SETTLE = 1800;
    localparam int WATCH_LIMIT = 20000;
    localparam int PHASE_ITEMS = 215;

    localparam lrk_pkg::oper_t STEP    = lrk_pkg::OPER_STEP;
    localparam lrk_pkg::oper_t RESTART = lrk_pkg::OPER_RESTART;

    typedef logic signed [VW-1:0] val_t;
    typedef val_t vec_t [3];

    localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam val_t ONE  = 48'h0010_0000_0000;
    localparam val_t NEG1 = '1;
    localparam val_t PAT5 = 48'h5555_5555_5555;
    localparam val_t PATA = 48'hAAAA_AAAA_AAAA;

    typedef struct {
        logic [CW-1:0] idx;
        val_t          px;
        val_t          py;
        val_t          pz;
    } traj_t;

    typedef struct {
        lrk_pkg::oper_t op;
        val_t           sx;
        val_t           sy;
        val_t           sz;
        bit             typed;
        logic [CW-1:0]  ei;
        val_t           ex;
        val_t           ey;
        val_t           ez;
    } dir_row_t;

    typedef struct {
        val_t          sig;
        val_t          rh;
        val_t          bt;
        logic [VW-2:0] ts;
        logic [CW-1:0] burn;
        logic [CW-1:0] stp;
        bit            quiet;
    } setting_t;

    localparam int DIR_N = 18;
    dir_row_t dir_table [DIR_N] = '{
        '{STEP,    0,    0,    0,    1, 0, ONE,  ONE,  ONE},
        '{STEP,    0,    0,    0,    0, 0, 0,    0,    0},
        '{RESTART, VMAX, VMIN, 0,    0, 0, 0,    0,    0},
        '{STEP,    PATA, PAT5, NEG1, 1, 0, VMAX, VMIN, 0},
        '{STEP,    0,    0,    0,    0, 0, 0,    0,    0},
        '{RESTART, VMIN, VMIN, VMIN, 0, 0, 0,    0,    0},
        '{STEP,    0,    0,    0,    1, 0, VMIN, VMIN, VMIN},
        '{STEP,    0,    0,    0,    0, 0, 0,    0,    0},
        '{RESTART, VMAX, VMAX, VMAX, 0, 0, 0,    0,    0},
        '{STEP,    0,    0,    0,    1, 0, VMAX, VMAX, VMAX},
        '{RESTART, 0,    0,    0,    0, 0, 0,    0,    0},
        '{STEP,    0,    0,    0,    1, 0, 0,    0,    0},
        '{STEP,    VMAX, VMAX, VMAX, 1, 1, 0,    0,    0},
        '{RESTART, NEG1, NEG1, NEG1, 0, 0, 0,    0,    0},
        '{STEP,    0,    0,    0,    1, 0, NEG1, NEG1, NEG1},
        '{RESTART, PAT5, PATA, ONE,  0, 0, 0,    0,    0},
        '{STEP,    PAT5, PATA, PAT5, 1, 0, PAT5, PATA, ONE},
        '{STEP,    0,    0,    0,    0, 0, 0,    0,    0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [VW-1:0]       cfg_data;

    lrk_cmd_if   #(.VALUE_WIDTH(VW))                  cmd ();
    lrk_point_if #(.VALUE_WIDTH(VW), .COUNT_WIDTH(CW)) point ();

    lorenz_rk4_integrator_top #(
        .VALUE_WIDTH   (VW),
        .FRACTION_BITS (FB),
        .COUNT_WIDTH   (CW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    val_t          m_sigma;
    val_t          m_rho;
    val_t          m_beta;
    logic [VW-2:0] m_ts;
    logic [CW-1:0] m_burn;
    logic [CW-1:0] m_stop;
    vec_t          m_pos;
    logic [CW-1:0] m_steps;

    traj_t         pending_points [$];
    int            errors = 0;
    int            idle_cycles = 0;
    bit            quiet;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic val_t clip(logic signed [VW+1:0] v);
        if (v > (VW+2)'(VMAX))
        begin
            return VMAX;
        end
        if (v < (VW+2)'(VMIN))
        begin
            return VMIN;
        end
        return val_t'(v);
    endfunction

    function automatic val_t fx_add(val_t a, val_t b);
        return clip((VW+2)'(a) + (VW+2)'(b));
    endfunction

    function automatic val_t fx_sub(val_t a, val_t b);
        return clip((VW+2)'(a) - (VW+2)'(b));
    endfunction

    function automatic val_t fx_mul(val_t a, val_t b);
        logic signed [2*VW-1:0] p;
        p = (2*VW)'(a) * (2*VW)'(b);
        p = p >>> FB;
        if (p > (2*VW)'(VMAX))
        begin
            return VMAX;
        end
        if (p < (2*VW)'(VMIN))
        begin
            return VMIN;
        end
        return val_t'(p);
    endfunction

    function automatic vec_t lorenz_rate(vec_t q);
        vec_t d;
        d[0] = fx_mul(m_sigma, fx_sub(q[1], q[0]));
        d[1] = fx_sub(fx_mul(q[0], fx_sub(m_rho, q[2])), q[1]);
        d[2] = fx_sub(fx_mul(q[0], q[1]), fx_mul(m_beta, q[2]));
        return d;
    endfunction

    function automatic void rk4_advance();
        vec_t k [4];
        vec_t q;
        val_t dt;
        val_t h;
        val_t acc;
        dt = {1'b0, m_ts};
        k[0] = lorenz_rate(m_pos);
        for (int s = 1; s < 4; s++)
        begin
            h = (s == 3) ? dt : (dt >>> 1);
            for (int i = 0; i < 3; i++)
            begin
                q[i] = fx_add(m_pos[i], fx_mul(k[s-1][i], h));
            end
            k[s] = lorenz_rate(q);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = fx_add(k[0][i], fx_add(k[1][i], k[1][i]));
            acc = fx_add(acc, fx_add(k[2][i], k[2][i]));
            acc = fx_add(acc, k[3][i]);
            m_pos[i] = fx_add(m_pos[i], fx_mul(acc, dt) / 48'sd6);
        end
    endfunction

    // Return 1 and the trajectory word when the word emits one.
    function automatic bit predict_point(lrk_pkg::oper_t op, val_t sx, val_t sy, val_t sz,
                                         output traj_t t);
        bit emit;
        emit = 1'b0;
        t = '{0, 0, 0, 0};
        if (op == lrk_pkg::OPER_RESTART)
        begin
            m_pos = '{sx, sy, sz};
            m_steps = '0;
            return 1'b0;
        end
        if (m_steps >= m_stop)
        begin
            return 1'b0;
        end
        if (m_steps >= m_burn)
        begin
            t = '{m_steps, m_pos[0], m_pos[1], m_pos[2]};
            emit = 1'b1;
        end
        rk4_advance();
        m_steps = m_steps + 1'b1;
        return emit;
    endfunction

    task automatic report(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(lrk_pkg::cfg_idx_t idx, logic [VW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            lrk_pkg::CFG_SIGMA:     m_sigma = data;
            lrk_pkg::CFG_RHO:       m_rho = data;
            lrk_pkg::CFG_BETA:      m_beta = data;
            lrk_pkg::CFG_TIME_STEP: m_ts = data[VW-2:0];
            lrk_pkg::CFG_BURN_IN:   m_burn = data[CW-1:0];
            lrk_pkg::CFG_STOP:      m_stop = data[CW-1:0];
            default:                ;
        endcase
    endtask

    task automatic apply_setting(setting_t s);
        write_reg(lrk_pkg::CFG_SIGMA, s.sig);
        write_reg(lrk_pkg::CFG_RHO, s.rh);
        write_reg(lrk_pkg::CFG_BETA, s.bt);
        write_reg(lrk_pkg::CFG_TIME_STEP, {1'b0, s.ts});
        write_reg(lrk_pkg::CFG_BURN_IN, VW'(s.burn));
        write_reg(lrk_pkg::CFG_STOP, VW'(s.stp));
        cfg_we <= 1'b0;
        quiet = s.quiet;
        @(posedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Drive one command word; typed rows override the predicted word.
    task automatic send_word(dir_row_t r);
        traj_t t;
        bit    emit;
        if (!quiet && $urandom_range(0, 99) < 11)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.operation <= r.op;
        cmd.start_x   <= r.sx;
        cmd.start_y   <= r.sy;
        cmd.start_z   <= r.sz;
        do
        begin
            @(posedge clk);
        end
        while (!cmd.ready);
        emit = predict_point(r.op, r.sx, r.sy, r.sz, t);
        if (r.typed)
        begin
            pending_points.push_back('{r.ei, r.ex, r.ey, r.ez});
        end
        else if (emit)
        begin
            pending_points.push_back(t);
        end
    endtask

    function automatic val_t rand_val();
        return val_t'({$urandom, $urandom});
    endfunction

    function automatic val_t rand_near();
        logic signed [FB+5:0] m;
        m = (FB+6)'({$urandom, $urandom});
        return val_t'(m);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            point.ready <= 1'b0;
        end
        else
        begin
            point.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge clk)
    begin
        if (point.valid && point.ready)
        begin
            if (pending_points.size() == 0)
            begin
                report("unexpected word", VW'(point.step_index), '0);
            end
            else
            begin
                traj_t w;
                w = pending_points.pop_front();
                if (point.step_index !== w.idx)
                begin
                    report("step_index", VW'(point.step_index), VW'(w.idx));
                end
                if (point.point_x !== w.px)
                begin
                    report("point_x", point.point_x, w.px);
                end
                if (point.point_y !== w.py)
                begin
                    report("point_y", point.point_y, w.py);
                end
                if (point.point_z !== w.pz)
                begin
                    report("point_z", point.point_z, w.pz);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (point.valid && point.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        setting_t plan [6];
        dir_row_t r;
        int       n;
        int       pick;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = lrk_pkg::CFG_SIGMA;
        cfg_data    = '0;
        cmd.valid     = 1'b0;
        cmd.operation = lrk_pkg::OPER_STEP;
        cmd.start_x   = '0;
        cmd.start_y   = '0;
        cmd.start_z   = '0;
        m_sigma = 48'sd687194767360;
        m_rho   = 48'sd1924145348608;
        m_beta  = 48'sd183251937963;
        m_ts    = 47'd6871948;
        m_burn  = 32'd1000000;
        m_stop  = 32'd11000000;
        m_pos   = '{ONE, ONE, ONE};
        m_steps = '0;

        plan[0] = '{48'sd687194767360, 48'sd1924145348608, 48'sd183251937963,
                    47'd6871948, 0, '1, 1'b0};
        plan[1] = '{VMAX, VMIN, VMAX, '1, 2, 5, 1'b0};
        plan[2] = '{VMIN, VMAX, VMIN, 0, 0, '1, 1'b1};
        plan[3] = '{val_t'(rand_near() <<< 1), val_t'(rand_near() <<< 1),
                    val_t'(rand_near() <<< 1), 47'($urandom_range(0, 687194767)),
                    1, 40, 1'b0};
        plan[4] = '{48'sd687194767360, 48'sd1924145348608, 48'sd183251937963,
                    47'd6871948, 10, 4, 1'b0};
        plan[5] = '{48'sd687194767360, 48'sd1924145348608, 48'sd183251937963,
                    47'd687194767, 0, 0, 1'b0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values stay except burn-in and stop, so the first word shows the reset point.
        write_reg(lrk_pkg::CFG_BURN_IN, '0);
        write_reg(lrk_pkg::CFG_STOP, VW'(1000));
        cfg_we <= 1'b0;
        @(posedge clk);
        foreach (dir_table[i])
        begin
            send_word(dir_table[i]);
        end
        drain();

        foreach (plan[p])
        begin
            apply_setting(plan[p]);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                r = '{STEP, rand_val(), rand_val(), rand_val(), 0, 0, 0, 0, 0};
                if (pick < 6)
                begin
                    r.op = RESTART;
                end
                else if (pick < 18)
                begin
                    r = '{RESTART, rand_near(), rand_near(), rand_near(),
                          0, 0, 0, 0, 0};
                end
                send_word(r);
                n++;
            end
            drain();
        end

        if (errors == 0 && pending_points.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
